[rtl/core/fbfl_pkg.sv]
package fbfl_pkg;

  // pool geometry
  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned LINK_W     = IDX_W + 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  // field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned CIDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BYTES = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TOTAL = 2'd2;

  // configuration reset values
  localparam logic [ADDR_W-1:0] BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] BYTES_RST = 16'd64;
  localparam logic [CNT_W-1:0]  TOTAL_RST = 11'd1024;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  free_cnt;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop;
    logic sweep;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic alloc_go;
    logic sweep_go;
    logic sweep_last;
  } sts_t;

endpackage

[rtl/core/fbfl_ctrl.sv]
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic q_room_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign take       = (state_q == S_IDLE) && q_room_i && in_valid_i;
  assign in_stall_o = !((state_q == S_IDLE) && q_room_i);

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = take;
    cmd_o.pop    = 1'b0;
    cmd_o.sweep  = 1'b0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take && sts_i.alloc_go) begin
          state_d = S_ALLOC;
        end else if (take && sts_i.sweep_go) begin
          state_d = S_SWEEP;
        end
      end
      S_ALLOC: begin
        cmd_o.pop = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // power-on starts with the relink sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/fbfl_dpath.sv]
module fbfl_dpath
  import fbfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [IDX_W-1:0]  release_index_i,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  output logic              push_o,
  output res_t              res_o
);

  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] bytes_q;
  logic [CNT_W-1:0]  total_q;

  logic [LINK_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  tally_q, tally_d;
  logic [CNT_W-1:0]  pool_q, pool_d;
  logic [IDX_W-1:0]  sweep_cnt_q, sweep_cnt_d;

  logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa;
  logic [LINK_W-1:0] mem_wd;

  logic              head_null, rel_ok, total_nz;
  logic [CNT_W-1:0]  lim_total, tally_inc, tally_dec;
  logic [IDX_W+SIZE_W-1:0] prod;

  assign head_null = (head_q >= NULL_LINK);
  assign rel_ok    = ({1'b0, release_index_i} < pool_q);
  assign total_nz  = (total_q != '0);
  assign lim_total = (total_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_q;
  assign tally_inc = (tally_q == CNT_W'(MAX_BLOCKS)) ? tally_q : tally_q + 1'b1;
  assign tally_dec = (tally_q == '0) ? tally_q : tally_q - 1'b1;
  assign prod      = head_q[IDX_W-1:0] * bytes_q;

  assign sts_o.alloc_go   = (op_i == OP_ALLOC) && !head_null;
  assign sts_o.sweep_go   = (op_i == OP_RESET) && total_nz;
  assign sts_o.sweep_last = ({1'b0, sweep_cnt_q} == pool_q - 1'b1);

  always_comb begin
    head_d      = head_q;
    tally_d     = tally_q;
    pool_d      = pool_q;
    sweep_cnt_d = sweep_cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wa      = sweep_cnt_q;
    mem_wd      = NULL_LINK;
    push_o      = 1'b0;
    res_o       = '{status: ST_OK, idx: '0, addr: '0, free_cnt: tally_q};

    if (cmd_i.sweep) begin
      mem_we      = 1'b1;
      mem_wa      = sweep_cnt_q;
      mem_wd      = sts_o.sweep_last ? NULL_LINK : LINK_W'(sweep_cnt_q) + 1'b1;
      sweep_cnt_d = sweep_cnt_q + 1'b1;
    end

    if (cmd_i.pop) begin
      head_d         = rd_q;
      tally_d        = tally_dec;
      push_o         = 1'b1;
      res_o.idx      = head_q[IDX_W-1:0];
      res_o.addr     = base_q + ADDR_W'(prod);
      res_o.free_cnt = tally_dec;
    end

    if (cmd_i.accept) begin
      push_o = !sts_o.alloc_go;
      case (op_i)
        OP_ALLOC: begin
          mem_re = 1'b1;
          if (head_null) begin
            res_o.status = ST_EXHAUSTED;
          end
        end
        OP_FREE: begin
          if (rel_ok) begin
            mem_we         = 1'b1;
            mem_wa         = release_index_i;
            mem_wd         = head_q;
            head_d         = {1'b0, release_index_i};
            tally_d        = tally_inc;
            res_o.free_cnt = tally_inc;
          end else begin
            res_o.status = ST_RANGE;
          end
        end
        OP_RESET: begin
          if (total_nz) begin
            head_d         = '0;
            tally_d        = lim_total;
            pool_d         = lim_total;
            sweep_cnt_d    = '0;
            res_o.free_cnt = lim_total;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= link_mem[head_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tally_q     <= CNT_W'(MAX_BLOCKS);
      pool_q      <= CNT_W'(MAX_BLOCKS);
      sweep_cnt_q <= '0;
    end else begin
      head_q      <= head_d;
      tally_q     <= tally_d;
      pool_q      <= pool_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      bytes_q <= BYTES_RST;
      total_q <= TOTAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE:  base_q  <= cfg_data_i;
        CFG_BYTES: bytes_q <= cfg_data_i[SIZE_W-1:0];
        CFG_TOTAL: total_q <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/fbfl_outq.sv]
module fbfl_outq
  import fbfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic room_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q != 2'd2) || pop;
  assign res_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/fixed_block_free_list_allocator.sv]
// fixed-size chunk pool with a lifo free list held in a next-link memory
//
// input channel: in_valid_i / in_stall_o with op_i and release_index_i;
//   an item is taken at a clock edge with valid high and stall low
// output channel: out_valid_o / out_stall_i with status_o, granted_index_o,
//   granted_address_o and blocks_free_o, one result per item, in order
// config channel: cfg_valid_i / cfg_ready_o, cfg_index_i picks base address,
//   chunk bytes or chunk total; ready is always high, total applies at reset op
// timing: free, pool reset and exhausted allocate finish in the accept cycle;
//   allocate reads the head's link synchronously, then pops from S_ALLOC
// throughput: input waits out that pop; a pool reset op then relinks the
//   link memory one entry per cycle over chunk total entries, capped at 1024
// reset: the link memory is relinked for all 1024 chunks, stall stays high
//   through that sweep, config registers return to defaults
// output stall: a two-entry result queue lets work go on while a result
//   waits; the queue stalls input only once it is full and not draining
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [IDX_W-1:0]  release_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [IDX_W-1:0]  granted_index_o,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [CNT_W-1:0]  blocks_free_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic q_room;
  logic push;
  res_t res_in, res_out;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: relink sweep, idle, allocate pop
  fbfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .q_room_i   (q_room),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // head, tally, link memory, address math and config registers
  fbfl_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .release_index_i (release_index_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .res_o           (res_in)
  );

  // result queue decouples the output stall
  fbfl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_in),
    .room_o      (q_room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign status_o          = res_out.status;
  assign granted_index_o   = res_out.idx;
  assign granted_address_o = res_out.addr;
  assign blocks_free_o     = res_out.free_cnt;

endmodule

[rtl/core/fbfl_checker.sv]
module fbfl_checker
  import fbfl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ST_W-1:0]   status_o,
  input logic [IDX_W-1:0]  granted_index_o,
  input logic [ADDR_W-1:0] granted_address_o,
  input logic [CNT_W-1:0]  blocks_free_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // failed operations grant nothing
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (granted_index_o == '0) && (granted_address_o == '0))
    else $error("grant fields set on failed operation");

  // an empty list means a zero free count
  a_empty_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EXHAUSTED) |-> (blocks_free_o == '0))
    else $error("pool exhausted with nonzero free count");

  // relink sweep holds off input right after reset
  a_rst_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during relink sweep");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (.*);
